[rtl/vhgc_pkg.sv]
`timescale 1ns / 1ps

package vhgc_pkg;

  // Capacity and widths
  localparam int MaxSamples     = 1024;
  localparam int SampleIdxW     = $clog2(MaxSamples);
  localparam int SampleCntW     = $clog2(MaxSamples + 1);
  localparam int MaxAlleleChars = 8;
  localparam int AlleleLenW     = $clog2(MaxAlleleChars + 2);
  localparam int AlleleTextW    = 8 * MaxAlleleChars;
  localparam int FirstSampleCol = 9;
  localparam int ColCap         = MaxSamples + 10;
  localparam int ColW           = $clog2(ColCap + 1);
  localparam int CountW         = 32;

  // Opcodes
  localparam logic OpFeed = 1'b0;
  localparam logic OpRead = 1'b1;

  // Sticky status codes
  localparam logic [2:0] ErrNone      = 3'd0;
  localparam logic [2:0] ErrNoSamples = 3'd1;
  localparam logic [2:0] ErrNoHeader  = 3'd2;
  localparam logic [2:0] ErrEmptyCall = 3'd3;
  localparam logic [2:0] ErrCapacity  = 3'd4;
  localparam logic [2:0] ErrAlleleLen = 3'd5;

  // Characters
  localparam logic [7:0] ChHash  = 8'h23;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChColon = 8'h3A;
  localparam logic [7:0] ChDot   = 8'h2E;
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChPipe  = 8'h7C;

  typedef struct packed {
    logic                  opcode;
    logic [7:0]            text_byte;
    logic [SampleIdxW-1:0] sample_index;
  } vhgc_in_t;

  typedef struct packed {
    logic [2:0]            status;
    logic [SampleCntW-1:0] samples_known;
    logic [CountW-1:0]     total_calls;
    logic [CountW-1:0]     het_calls;
  } vhgc_out_t;

  typedef enum logic [1:0] {
    EvNone  = 2'd0,
    EvCount = 2'd1,
    EvRead  = 2'd2
  } vhgc_ev_e;

  // Event handed from parser to counter store
  typedef struct packed {
    vhgc_ev_e              kind;
    logic                  het;
    logic [SampleIdxW-1:0] idx;
    logic [2:0]            status;
    logic [SampleCntW-1:0] samples;
  } vhgc_ev_t;

  // Header keyword "#CHROM", by position
  function automatic logic [7:0] hdr_char(input logic [2:0] pos);
    logic [7:0] c;
    case (pos)
      3'd0:    c = 8'h23;
      3'd1:    c = 8'h43;
      3'd2:    c = 8'h48;
      3'd3:    c = 8'h52;
      3'd4:    c = 8'h4F;
      3'd5:    c = 8'h4D;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

[rtl/vhgc_front.sv]
`timescale 1ns / 1ps

module vhgc_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               fire_i,
  input  vhgc_pkg::vhgc_in_t in_word_i,
  output vhgc_pkg::vhgc_ev_t ev_o
);

  localparam logic [1:0] ModeLine    = 2'd0;
  localparam logic [1:0] ModeComment = 2'd1;
  localparam logic [1:0] ModeHeader  = 2'd2;
  localparam logic [1:0] ModeData    = 2'd3;

  localparam int FlDot   = 0;
  localparam int FlCut   = 1;
  localparam int FlField = 2;
  localparam int FlGeno  = 3;

  localparam int LW = vhgc_pkg::AlleleLenW;
  localparam int TW = vhgc_pkg::AlleleTextW;
  localparam int CW = vhgc_pkg::ColW;
  localparam int SW = vhgc_pkg::SampleCntW;

  localparam logic [LW-1:0] LenMax  = LW'(vhgc_pkg::MaxAlleleChars);
  localparam logic [LW-1:0] LenOver = LW'(vhgc_pkg::MaxAlleleChars + 1);
  localparam logic [CW-1:0] ColFirst = CW'(vhgc_pkg::FirstSampleCol);
  localparam logic [CW-1:0] ColCapV  = CW'(vhgc_pkg::ColCap);
  localparam logic [SW-1:0] SampMax  = SW'(vhgc_pkg::MaxSamples);

  logic [1:0]    mode_q, mode_d;
  logic [CW-1:0] col_q, col_d;
  logic [2:0]    pos_q, pos_d;
  logic [SW-1:0] samp_q, samp_d;
  logic [TW-1:0] fa_txt_q, fa_txt_d, seg_txt_q, seg_txt_d;
  logic [LW-1:0] fa_len_q, fa_len_d, seg_len_q, seg_len_d;
  logic [3:0]    flags_q, flags_d;
  logic [7:0]    pend_q, pend_d;
  logic [2:0]    err_q, err_d;

  logic                            upd, het;
  logic [vhgc_pkg::SampleIdxW-1:0] uidx;

  // Byte parser: one byte per word
  always_comb begin
    logic [7:0]    b;
    logic          data_path, do_fin;
    logic [8:0]    len_sum;
    logic [TW-1:0] fill;
    logic [CW-1:0] idx;
    logic [CW:0]   parts;
    logic [CW:0]   add;
    mode_d    = mode_q;
    col_d     = col_q;
    pos_d     = pos_q;
    samp_d    = samp_q;
    fa_txt_d  = fa_txt_q;
    fa_len_d  = fa_len_q;
    seg_txt_d = seg_txt_q;
    seg_len_d = seg_len_q;
    flags_d   = flags_q;
    pend_d    = pend_q;
    err_d     = err_q;
    upd       = 1'b0;
    het       = 1'b0;
    uidx      = '0;
    b         = in_word_i.text_byte;
    data_path = 1'b0;
    do_fin    = 1'b0;
    len_sum   = '0;
    fill      = '0;
    idx       = '0;
    parts     = '0;
    add       = '0;

    if (in_word_i.opcode == vhgc_pkg::OpFeed && err_q == vhgc_pkg::ErrNone) begin
      case (mode_q)
        ModeLine: begin
          col_d     = '0;
          pos_d     = '0;
          pend_d    = '0;
          fa_txt_d  = '0;
          fa_len_d  = '0;
          seg_txt_d = '0;
          seg_len_d = '0;
          flags_d   = '0;
          if (b == vhgc_pkg::ChHash) begin
            mode_d          = ModeHeader;
            pos_d           = 3'd1;
            flags_d[FlField] = 1'b1;
          end else if (samp_q == '0) begin
            err_d = vhgc_pkg::ErrNoHeader;
          end else begin
            mode_d    = ModeData;
            data_path = 1'b1;
          end
        end
        ModeComment: begin
          if (b == vhgc_pkg::ChLf) mode_d = ModeLine;
        end
        ModeHeader: begin
          if (b == vhgc_pkg::ChLf) begin
            if (pos_q == 3'd7) begin
              parts = {1'b0, col_q} + (CW+1)'(flags_q[FlField]);
              if (parts < (CW+1)'(vhgc_pkg::FirstSampleCol + 1)) begin
                err_d = vhgc_pkg::ErrNoSamples;
              end else begin
                add = parts - (CW+1)'(vhgc_pkg::FirstSampleCol);
                if (add > (CW+1)'(SampMax - samp_q)) samp_d = SampMax;
                else samp_d = samp_q + SW'(add);
              end
            end
            mode_d = ModeLine;
          end else if (pos_q < 3'd6) begin
            if (b == vhgc_pkg::hdr_char(pos_q)) pos_d = pos_q + 3'd1;
            else mode_d = ModeComment;
          end else begin
            pos_d = 3'd7;
            if (b == vhgc_pkg::ChTab) begin
              if (col_q < ColCapV) col_d = col_q + CW'(1);
              flags_d[FlField] = 1'b0;
            end else begin
              flags_d[FlField] = 1'b1;
            end
          end
        end
        default: data_path = 1'b1;
      endcase

      // Data line byte
      if (data_path) begin
        if (b == vhgc_pkg::ChCr) begin
          if (pend_d != 8'hFF) pend_d = pend_d + 8'd1;
        end else if (b == vhgc_pkg::ChLf) begin
          pend_d = '0;
          do_fin = flags_d[FlField];
          mode_d = ModeLine;
        end else begin
          // held-back CRs become text
          if (pend_d != '0) begin
            flags_d[FlField] = 1'b1;
            if (col_d >= ColFirst && !flags_d[FlCut]) begin
              flags_d[FlGeno] = 1'b1;
              len_sum = 9'(seg_len_d) + 9'(pend_d);
              if (len_sum > 9'(LenMax)) begin
                seg_len_d = LenOver;
              end else begin
                for (int i = 0; i < vhgc_pkg::MaxAlleleChars; i++) begin
                  if (9'(i) < 9'(pend_d)) fill[8*i +: 8] = vhgc_pkg::ChCr;
                end
                seg_txt_d = (seg_txt_d << {pend_d[3:0], 3'b000}) | fill;
                seg_len_d = LW'(len_sum);
              end
            end
          end
          pend_d = '0;
          if (b == vhgc_pkg::ChTab) begin
            do_fin = 1'b1;
          end else begin
            flags_d[FlField] = 1'b1;
            if (col_d >= ColFirst && !flags_d[FlCut]) begin
              if (b == vhgc_pkg::ChColon) begin
                flags_d[FlCut] = 1'b1;
              end else begin
                flags_d[FlGeno] = 1'b1;
                if (b == vhgc_pkg::ChDot) flags_d[FlDot] = 1'b1;
                if (b == vhgc_pkg::ChSlash || b == vhgc_pkg::ChPipe) begin
                  if (fa_len_d == '0) begin
                    fa_txt_d = seg_txt_d;
                    fa_len_d = seg_len_d;
                  end
                  seg_txt_d = '0;
                  seg_len_d = '0;
                end else if (seg_len_d < LenMax) begin
                  seg_txt_d = {seg_txt_d[TW-9:0], b};
                  seg_len_d = seg_len_d + LW'(1);
                end else begin
                  seg_len_d = LenOver;
                end
              end
            end
          end
        end

        // Field end: judge the call
        if (do_fin) begin
          if (col_d >= ColFirst && !flags_d[FlDot]) begin
            idx = col_d - ColFirst;
            if (!flags_d[FlGeno]) begin
              err_d = vhgc_pkg::ErrEmptyCall;
            end else if ((SW+CW)'(idx) >= (SW+CW)'(samp_q)) begin
              err_d = vhgc_pkg::ErrCapacity;
            end else if (fa_len_d > LenMax || seg_len_d > LenMax) begin
              err_d = vhgc_pkg::ErrAlleleLen;
            end else begin
              upd  = 1'b1;
              uidx = idx[vhgc_pkg::SampleIdxW-1:0];
              het  = (fa_len_d != seg_len_d) || (fa_txt_d != seg_txt_d);
            end
          end
          fa_txt_d  = '0;
          fa_len_d  = '0;
          seg_txt_d = '0;
          seg_len_d = '0;
          flags_d   = '0;
          if (col_d < ColCapV) col_d = col_d + CW'(1);
        end
      end
    end
  end

  // Event for the back end
  always_comb begin
    ev_o.status  = err_d;
    ev_o.samples = samp_d;
    ev_o.het     = het;
    if (in_word_i.opcode == vhgc_pkg::OpRead) begin
      ev_o.kind = vhgc_pkg::EvRead;
      ev_o.idx  = in_word_i.sample_index;
    end else begin
      ev_o.kind = upd ? vhgc_pkg::EvCount : vhgc_pkg::EvNone;
      ev_o.idx  = uidx;
    end
  end

  // Parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= ModeLine;
      col_q     <= '0;
      pos_q     <= '0;
      samp_q    <= '0;
      fa_txt_q  <= '0;
      fa_len_q  <= '0;
      seg_txt_q <= '0;
      seg_len_q <= '0;
      flags_q   <= '0;
      pend_q    <= '0;
      err_q     <= vhgc_pkg::ErrNone;
    end else if (fire_i) begin
      mode_q    <= mode_d;
      col_q     <= col_d;
      pos_q     <= pos_d;
      samp_q    <= samp_d;
      fa_txt_q  <= fa_txt_d;
      fa_len_q  <= fa_len_d;
      seg_txt_q <= seg_txt_d;
      seg_len_q <= seg_len_d;
      flags_q   <= flags_d;
      pend_q    <= pend_d;
      err_q     <= err_d;
    end
  end

endmodule

[rtl/vhgc_fifo.sv]
`timescale 1ns / 1ps

module vhgc_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  vhgc_pkg::vhgc_ev_t push_ev_i,
  input  logic               pop_i,
  output vhgc_pkg::vhgc_ev_t head_o,
  output logic               empty_o,
  output logic               full_o
);

  vhgc_pkg::vhgc_ev_t ent_q [4];
  logic [1:0] wr_q, rd_q;
  logic [2:0] cnt_q;

  assign head_o  = ent_q[rd_q];
  assign empty_o = (cnt_q == 3'd0);
  assign full_o  = (cnt_q == 3'd4);

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) ent_q[wr_q] <= push_ev_i;
  end

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 2'd1;
      if (pop_i)  rd_q <= rd_q + 2'd1;
      cnt_q <= cnt_q + 3'(push_i) - 3'(pop_i);
    end
  end

endmodule

[rtl/vhgc_back.sv]
`timescale 1ns / 1ps

module vhgc_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  vhgc_pkg::vhgc_ev_t  ev_i,
  input  logic                ev_valid_i,
  output logic                pop_o,
  output logic                clearing_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output vhgc_pkg::vhgc_out_t out_word_o
);

  localparam int IW = vhgc_pkg::SampleIdxW;
  localparam int NW = vhgc_pkg::CountW;

  // {het, total} per sample
  logic [2*NW-1:0] mem [vhgc_pkg::MaxSamples];
  logic [2*NW-1:0] rd_q;

  logic          busy_q;
  logic [IW-1:0] clr_q;

  logic               s2_v_q, fwd_q;
  vhgc_pkg::vhgc_ev_t s2_q;
  logic [NW-1:0]      fwd_tot_q, fwd_het_q;

  logic                out_v_q;
  vhgc_pkg::vhgc_out_t out_q;

  logic          s2_adv, s2_fire, wr_en;
  logic [NW-1:0] base_tot, base_het, new_tot, new_het;

  assign s2_adv  = !out_v_q || !out_stall_i;
  assign s2_fire = s2_v_q && s2_adv;
  assign pop_o   = ev_valid_i && !busy_q && (!s2_v_q || s2_adv);
  assign wr_en   = s2_fire && s2_q.kind == vhgc_pkg::EvCount;

  // Counter update with bypass of the word written alongside this read
  assign base_tot = fwd_q ? fwd_tot_q : rd_q[NW-1:0];
  assign base_het = fwd_q ? fwd_het_q : rd_q[2*NW-1:NW];
  assign new_tot  = base_tot + NW'(1);
  assign new_het  = base_het + NW'(s2_q.het);

  // Counter store
  always_ff @(posedge clk_i) begin
    if (busy_q) mem[clr_q] <= '0;
    else if (wr_en) mem[s2_q.idx] <= {new_het, new_tot};
    if (pop_o) rd_q <= mem[ev_i.idx];
  end

  // Payload of stage two and output
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      s2_q      <= ev_i;
      fwd_tot_q <= new_tot;
      fwd_het_q <= new_het;
    end
    if (s2_fire) begin
      out_q.status        <= s2_q.status;
      out_q.samples_known <= s2_q.samples;
      case (s2_q.kind)
        vhgc_pkg::EvRead: begin
          out_q.total_calls <= base_tot;
          out_q.het_calls   <= base_het;
        end
        default: begin
          out_q.total_calls <= '0;
          out_q.het_calls   <= '0;
        end
      endcase
    end
  end

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b1;
      clr_q   <= '0;
      s2_v_q  <= 1'b0;
      fwd_q   <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (busy_q) begin
        clr_q <= clr_q + IW'(1);
        if (clr_q == {IW{1'b1}}) busy_q <= 1'b0;
      end
      if (pop_o) begin
        s2_v_q <= 1'b1;
        fwd_q  <= wr_en && (s2_q.idx == ev_i.idx);
      end else if (s2_fire) begin
        s2_v_q <= 1'b0;
        fwd_q  <= 1'b0;
      end
      if (s2_fire) out_v_q <= 1'b1;
      else if (!out_stall_i) out_v_q <= 1'b0;
    end
  end

  assign clearing_o  = busy_q;
  assign out_valid_o = out_v_q;
  assign out_word_o  = out_q;

`ifndef ASSERT_OFF
  a_idle_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !s2_v_q && !out_v_q)
    else $error("work in flight during counter clear");
  a_fwd_needs_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fwd_q |-> s2_v_q)
    else $error("bypass flag without stage-two entry");
  a_no_write_on_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> s2_q.kind == vhgc_pkg::EvCount && !busy_q)
    else $error("counter write outside a count event");
  a_out_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && out_stall_i |=> out_v_q)
    else $error("stalled result dropped");
`endif

endmodule

[rtl/vcf_het_genotype_counter.sv]
`timescale 1ns / 1ps

// Streaming VCF heterozygosity counter. Each word is either one text byte or
// a counter read for one sample, and each word gives exactly one result word
// carrying the sticky status and the number of samples known. The parser
// takes one word per cycle while the input is not stalled; the event of every
// word passes through a four-entry queue to a counter store with one read and
// one write port behind a read-modify-write pipeline, so the sustained rate is
// one word per clock when the output is not stalled. A result word is held in
// the queue, the read stage and the output register. After reset the store is
// zeroed by a pass over every entry, during which the input is stalled.
module vcf_het_genotype_counter (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  vhgc_pkg::vhgc_in_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output vhgc_pkg::vhgc_out_t out_word_o
);

  vhgc_pkg::vhgc_ev_t fe_ev, q_head;
  logic fire, q_empty, q_full, q_pop, clearing;

  assign in_stall_o = clearing || q_full;
  assign fire       = in_valid_i && !in_stall_o;

  vhgc_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (fire),
    .in_word_i (in_word_i),
    .ev_o      (fe_ev)
  );

  vhgc_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (fire),
    .push_ev_i (fe_ev),
    .pop_i     (q_pop),
    .head_o    (q_head),
    .empty_o   (q_empty),
    .full_o    (q_full)
  );

  vhgc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ev_i        (q_head),
    .ev_valid_i  (!q_empty),
    .pop_o       (q_pop),
    .clearing_o  (clearing),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule

[verif/vcf_het_genotype_counter_test.sv]
`timescale 1ns / 1ps

module vcf_het_genotype_counter_test;
  import vhgc_pkg::*;

  localparam int CycleLimit = 400000;

  // Parser modes and call flags of the scoreboard's own parser
  localparam int ModeLine    = 0;
  localparam int ModeComment = 1;
  localparam int ModeHeader  = 2;
  localparam int ModeData    = 3;
  localparam int FlDot   = 1;
  localparam int FlCut   = 2;
  localparam int FlField = 4;
  localparam int FlGeno  = 8;
  localparam string HdrWord = "#CHROM";

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  vhgc_in_t  in_word_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  vhgc_out_t out_word_o;

  vcf_het_genotype_counter dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_word_i,
    .out_valid_o, .out_stall_i, .out_word_o
  );

  always #5 clk_i = ~clk_i;

  // Scoreboard parser state
  int          gt_mode, gt_col, gt_hpos, gt_samples, gt_flags, gt_cr;
  int          gt_flen, gt_slen;
  logic [63:0] gt_ftext, gt_stext;
  logic [2:0]  gt_err;
  logic [31:0] tot_mem [MaxSamples];
  logic [31:0] het_mem [MaxSamples];

  vhgc_out_t   awaited_words [$];
  int          words_sent, words_seen, failures, cycles;
  bit          calm;

  function automatic void clear_call();
    gt_ftext = '0;
    gt_flen  = 0;
    gt_stext = '0;
    gt_slen  = 0;
    gt_flags = 0;
  endfunction

  function automatic void next_column();
    if (gt_col < ColCap) gt_col++;
  endfunction

  function automatic void call_char(logic [7:0] c);
    gt_flags |= FlField;
    if (gt_col < FirstSampleCol || (gt_flags & FlCut) != 0) return;
    if (c == ChColon) begin
      gt_flags |= FlCut;
      return;
    end
    gt_flags |= FlGeno;
    if (c == ChDot) gt_flags |= FlDot;
    if (c == ChSlash || c == ChPipe) begin
      if (gt_flen == 0) begin
        gt_ftext = gt_stext;
        gt_flen  = gt_slen;
      end
      gt_stext = '0;
      gt_slen  = 0;
      return;
    end
    if (gt_slen < MaxAlleleChars) begin
      gt_stext = {gt_stext[55:0], c};
      gt_slen++;
    end else begin
      gt_slen = MaxAlleleChars + 1;
    end
  endfunction

  // Close a field: count the call if it is one
  function automatic void close_field();
    int idx;
    if (gt_col >= FirstSampleCol && (gt_flags & FlDot) == 0) begin
      idx = gt_col - FirstSampleCol;
      if ((gt_flags & FlGeno) == 0) begin
        gt_err = ErrEmptyCall;
      end else if (idx >= gt_samples || idx >= MaxSamples) begin
        gt_err = ErrCapacity;
      end else if (gt_flen > MaxAlleleChars || gt_slen > MaxAlleleChars) begin
        gt_err = ErrAlleleLen;
      end else begin
        tot_mem[idx] = tot_mem[idx] + 1;
        if (gt_flen != gt_slen || gt_ftext != gt_stext) het_mem[idx] = het_mem[idx] + 1;
      end
    end
    clear_call();
    next_column();
  endfunction

  function automatic void data_text(logic [7:0] b);
    if (b == ChCr) begin
      if (gt_cr < 255) gt_cr++;
      return;
    end
    if (b == ChLf) begin
      gt_cr = 0;
      if ((gt_flags & FlField) != 0) close_field();
      gt_mode = ModeLine;
      return;
    end
    while (gt_cr > 0) begin
      gt_cr--;
      call_char(ChCr);
    end
    if (b == ChTab) close_field();
    else call_char(b);
  endfunction

  function automatic void header_text(logic [7:0] b);
    int parts;
    if (b == ChLf) begin
      if (gt_hpos == 7) begin
        parts = gt_col + (((gt_flags & FlField) != 0) ? 1 : 0);
        if (parts < 10) gt_err = ErrNoSamples;
        else if (parts - 9 > MaxSamples - gt_samples) gt_samples = MaxSamples;
        else gt_samples += parts - 9;
      end
      gt_mode = ModeLine;
      return;
    end
    if (gt_hpos < 6) begin
      if (b == HdrWord[gt_hpos]) gt_hpos++;
      else gt_mode = ModeComment;
      return;
    end
    gt_hpos = 7;
    if (b == ChTab) begin
      next_column();
      gt_flags &= ~FlField;
    end else begin
      gt_flags |= FlField;
    end
  endfunction

  function automatic void parse_byte(logic [7:0] b);
    if (gt_err != ErrNone) return;
    case (gt_mode)
      ModeLine: begin
        gt_col  = 0;
        gt_hpos = 0;
        gt_cr   = 0;
        clear_call();
        if (b == ChHash) begin
          gt_mode  = ModeHeader;
          gt_hpos  = 1;
          gt_flags = FlField;
        end else if (gt_samples == 0) begin
          gt_err = ErrNoHeader;
        end else begin
          gt_mode = ModeData;
          data_text(b);
        end
      end
      ModeComment: if (b == ChLf) gt_mode = ModeLine;
      ModeHeader:  header_text(b);
      default:     data_text(b);
    endcase
  endfunction

  // Expected result word for one accepted word
  function automatic vhgc_out_t predict_result(vhgc_in_t w);
    vhgc_out_t r;
    r = '0;
    if (w.opcode == OpFeed) begin
      parse_byte(w.text_byte);
    end else begin
      r.total_calls = tot_mem[w.sample_index];
      r.het_calls   = het_mem[w.sample_index];
    end
    r.status        = gt_err;
    r.samples_known = gt_samples[SampleCntW-1:0];
    return r;
  endfunction

  // Send one word; a typed expectation replaces the predicted one
  task automatic send_word(vhgc_in_t w, bit typed = 1'b0, vhgc_out_t typed_res = '0);
    vhgc_out_t r;
    while (!calm && $urandom_range(0, 99) < 38) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    r = predict_result(w);
    awaited_words.insert(awaited_words.size(), typed ? typed_res : r);
    words_sent++;
  endtask

  task automatic send_read(int idx);
    vhgc_in_t w;
    w = '0;
    w.opcode       = OpRead;
    w.text_byte    = 8'($urandom);
    w.sample_index = SampleIdxW'(idx);
    send_word(w);
  endtask

  // Text byte, with a counter read slipped in now and then
  task automatic send_byte(logic [7:0] b);
    vhgc_in_t w;
    if ($urandom_range(0, 9) == 0)
      send_read($urandom_range(0, 3) == 0 ? $urandom_range(0, 1023) : $urandom_range(0, 7));
    w = '0;
    w.opcode       = OpFeed;
    w.text_byte    = b;
    w.sample_index = SampleIdxW'($urandom);
    send_word(w);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  function automatic string rand_allele();
    case ($urandom_range(0, 5))
      0:       return "0";
      1:       return "1";
      2:       return "2";
      3:       return "10";
      4:       return "A";
      default: return "GT";
    endcase
  endfunction

  function automatic string rand_call();
    string a, b;
    a = rand_allele();
    b = rand_allele();
    case ($urandom_range(0, 7))
      0:       return "./.";
      1:       return {a, "/", b};
      2:       return {a, "|", b};
      3:       return a;
      4:       return {"/", a, "/", b};
      5:       return {a, "/", b, ":", a, ":."};
      6:       return {a, "/", a};
      default: return {a, "|", b, "|", a};
    endcase
  endfunction

  function automatic logic [7:0] rand_text_byte();
    logic [7:0] b;
    do b = 8'($urandom); while (b == ChTab || b == ChLf);
    return b;
  endfunction

  task automatic send_data_line();
    int m;
    for (int f = 0; f < FirstSampleCol; f++) begin
      repeat ($urandom_range(0, 3)) send_byte(rand_text_byte());
      send_byte(ChTab);
    end
    m = $urandom_range(1, gt_samples < 6 ? gt_samples : 6);
    for (int k = 0; k < m; k++) begin
      send_text(rand_call());
      if (k < m - 1 || $urandom_range(0, 3) == 0) send_byte(ChTab);
    end
    if ($urandom_range(0, 3) == 0) send_text("\r\r");
    send_byte(ChLf);
  endtask

  task automatic send_header(int extra);
    send_text("#CHROM");
    for (int f = 0; f < 8 + extra; f++) send_text("\tS");
    send_byte(ChLf);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (awaited_words.size() != 0) @(posedge clk_i);
  endtask

  // Result checker
  always @(posedge clk_i) begin
    vhgc_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      words_seen++;
      if (awaited_words.size() == 0) begin
        $error("result word with nothing awaited");
        failures++;
      end else begin
        want = awaited_words.pop_front();
        if (out_word_o.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_word_o.status);
          failures++;
        end
        if (out_word_o.samples_known !== want.samples_known) begin
          $error("samples_known: expected %0d, got %0d",
                 want.samples_known, out_word_o.samples_known);
          failures++;
        end
        if (out_word_o.total_calls !== want.total_calls) begin
          $error("total_calls: expected %0d, got %0d",
                 want.total_calls, out_word_o.total_calls);
          failures++;
        end
        if (out_word_o.het_calls !== want.het_calls) begin
          $error("het_calls: expected %0d, got %0d", want.het_calls, out_word_o.het_calls);
          failures++;
        end
      end
    end
  end

  // Receiver: random stalls, one long hold-off to back the block up
  initial begin
    int hold_left;
    bit held;
    hold_left = 0;
    held = 1'b0;
    forever begin
      @(posedge clk_i);
      if (!held && words_seen >= 150) begin
        held = 1'b1;
        hold_left = 120;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= !calm && ($urandom_range(0, 99) < 38);
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("FAIL vcf_het_genotype_counter");
      $finish;
    end
  end

  typedef struct {
    logic       opcode;
    logic [7:0] text;
    int         idx;
    bit         typed;
    vhgc_out_t  res;
  } stim_row_t;

  stim_row_t dir_tab [$];

  initial begin
    vhgc_in_t w;
    string hdr;
    bit drained;
    gt_mode = ModeLine;
    gt_col = 0;
    gt_hpos = 0;
    gt_samples = 0;
    gt_cr = 0;
    gt_err = ErrNone;
    drained = 1'b0;
    clear_call();
    foreach (tot_mem[i]) begin
      tot_mem[i] = '0;
      het_mem[i] = '0;
    end

    // Directed table: reads after reset, a comment with a high byte, minimal header
    dir_tab.insert(dir_tab.size(), '{OpRead, 8'h00, 0, 1'b1, '{ErrNone, 11'd0, 32'd0, 32'd0}});
    dir_tab.insert(dir_tab.size(),
                   '{OpRead, 8'hFF, 1023, 1'b1, '{ErrNone, 11'd0, 32'd0, 32'd0}});
    dir_tab.insert(dir_tab.size(), '{OpFeed, ChHash, 0, 1'b0, '0});
    dir_tab.insert(dir_tab.size(), '{OpFeed, 8'hFF, 1023, 1'b0, '0});
    dir_tab.insert(dir_tab.size(), '{OpFeed, ChLf, 0, 1'b0, '0});
    hdr = "#CHROM\t\t\t\t\t\t\t\t\tx\n";
    for (int i = 0; i < hdr.len(); i++)
      dir_tab.insert(dir_tab.size(), '{OpFeed, hdr[i], 0, 1'b0, '0});
    dir_tab.insert(dir_tab.size(), '{OpRead, 8'h00, 0, 1'b1, '{ErrNone, 11'd1, 32'd0, 32'd0}});

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_tab[i]) begin
      w.opcode       = dir_tab[i].opcode;
      w.text_byte    = dir_tab[i].text;
      w.sample_index = SampleIdxW'(dir_tab[i].idx);
      send_word(w, dir_tab[i].typed, dir_tab[i].res);
    end

    // Well-formed lines with random content, one pause until all results are in
    while (words_sent < 520) begin
      if (!drained && words_sent > 300) begin
        drain();
        drained = 1'b1;
      end
      case ($urandom_range(0, 19))
        0, 1, 2: send_text({"##x=", rand_allele(), "\n"});
        3, 4:    send_header($urandom_range(1, 3));
        5:       send_byte(ChLf);
        default: send_data_line();
      endcase
    end

    // Wide header saturates the sample count; sent without idling
    calm = 1'b1;
    send_text("#CHROM");
    repeat (MaxSamples) send_byte(ChTab);
    send_text("x\n");
    calm = 1'b0;

    while (words_sent < 1600) send_data_line();
    for (int i = 0; i < 16; i++) send_read(i);

    // Finish with one fault, then noise
    case ($urandom_range(0, 4))
      0:       repeat (60) send_byte(8'($urandom));
      1:       send_text("a\tb\tc\td\te\tf\tg\th\ti\t\t0\n");
      2:       send_text("a\tb\tc\td\te\tf\tg\th\ti\t123456789/1\n");
      3:       send_text("#CHROM\tx\n");
      default: send_text("a\tb\tc\td\te\tf\tg\th\ti\t:x\n");
    endcase
    repeat (30) begin
      if ($urandom_range(0, 1) == 0) send_read($urandom_range(0, 1023));
      else send_byte(8'($urandom));
    end

    drain();
    repeat (20) @(posedge clk_i);
    $display("Run sent %0d words and checked %0d results; %0d samples known, status %0d.",
             words_sent, words_seen, gt_samples, gt_err);
    if (failures == 0 && awaited_words.size() == 0) begin
      $display("PASS vcf_het_genotype_counter");
    end else begin
      $display("FAIL vcf_het_genotype_counter");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/vhgc_pkg.sv
rtl/vhgc_front.sv
rtl/vhgc_fifo.sv
rtl/vhgc_back.sv
rtl/vcf_het_genotype_counter.sv
verif/vcf_het_genotype_counter_test.sv
